/* src/fpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Types, constants and codes shared by the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 8;
    localparam int DVD_BITS   = WORD_BITS + FRAC_BITS;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = (DVD_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int LATENCY    = DIV_STAGES + 4;

    localparam logic [3:0] FN_ADD = 4'd0;
    localparam logic [3:0] FN_SUB = 4'd1;
    localparam logic [3:0] FN_MUL = 4'd2;
    localparam logic [3:0] FN_DIV = 4'd3;
    localparam logic [3:0] FN_MIN = 4'd4;
    localparam logic [3:0] FN_MAX = 4'd5;
    localparam logic [3:0] FN_INC = 4'd6;
    localparam logic [3:0] FN_DEC = 4'd7;
    localparam logic [3:0] FN_INT = 4'd8;
    localparam logic [3:0] FN_FRM = 4'd9;
    localparam logic [3:0] FN_CMP = 4'd10;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        logic [3:0]                  func;
        logic signed [WORD_BITS-1:0] operand_a;
        logic signed [WORD_BITS-1:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] result;
        logic                        less;
        logic                        equal;
        logic                        greater;
        logic [1:0]                  status;
    } t_out;

    typedef struct packed {
        logic [3:0]             func;
        logic                   neg;
        logic [WORD_BITS-1:0]   simple;
        logic [1:0]             simple_st;
        logic                   less;
        logic                   equal;
        logic                   greater;
        logic [2*WORD_BITS-1:0] prod;
    } t_side;

endpackage

/* src/fpa_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider, DIV_STEPS quotient bits per stage.
// ----------------------------------------------------------------------------
module fpa_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [fpa_pkg::DVD_BITS-1:0]   i_dvd,
    input  logic [fpa_pkg::WORD_BITS-1:0]  i_dvs,
    input  fpa_pkg::t_side                 i_side,
    output logic                           o_valid,
    output logic [fpa_pkg::DVD_BITS-1:0]   o_quo,
    output logic [fpa_pkg::WORD_BITS-1:0]  o_rem,
    output logic [fpa_pkg::WORD_BITS-1:0]  o_dvs,
    output fpa_pkg::t_side                 o_side
);

    localparam int W = fpa_pkg::WORD_BITS;
    localparam int D = fpa_pkg::DVD_BITS;
    localparam int S = fpa_pkg::DIV_STAGES;

    logic           r_vld  [S];
    logic [D-1:0]   r_q    [S];
    logic [W-1:0]   r_rem  [S];
    logic [W-1:0]   r_dvs  [S];
    fpa_pkg::t_side r_side [S];

    genvar g;
    generate
        for (g = 0; g < S; g++) begin : g_stage
            logic           in_vld;
            logic [D-1:0]   in_q;
            logic [W-1:0]   in_rem;
            logic [W-1:0]   in_dvs;
            fpa_pkg::t_side in_side;
            logic [D-1:0]   n_q;
            logic [W-1:0]   n_rem;

            if (g == 0) begin : g_first
                assign in_vld  = i_valid;
                assign in_q    = i_dvd;
                assign in_rem  = '0;
                assign in_dvs  = i_dvs;
                assign in_side = i_side;
            end else begin : g_next
                assign in_vld  = r_vld[g-1];
                assign in_q    = r_q[g-1];
                assign in_rem  = r_rem[g-1];
                assign in_dvs  = r_dvs[g-1];
                assign in_side = r_side[g-1];
            end

            always_comb begin
                logic [W:0] t;
                n_q   = in_q;
                n_rem = in_rem;
                for (int k = 0; k < fpa_pkg::DIV_STEPS; k++) begin
                    t   = {n_rem, n_q[D-1]};
                    n_q = {n_q[D-2:0], 1'b0};
                    if (t >= {1'b0, in_dvs}) begin
                        t      = t - {1'b0, in_dvs};
                        n_q[0] = 1'b1;
                    end
                    n_rem = t[W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else begin
                    r_vld[g] <= in_vld;
                end
                r_q[g]    <= n_q;
                r_rem[g]  <= n_rem;
                r_dvs[g]  <= in_dvs;
                r_side[g] <= in_side;
            end
        end
    endgenerate

    assign o_valid = r_vld[S-1];
    assign o_quo   = r_q[S-1];
    assign o_rem   = r_rem[S-1];
    assign o_dvs   = r_dvs[S-1];
    assign o_side  = r_side[S-1];

endmodule

/* src/fixed_point_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed Q24.8 ALU: add, sub, mul, div, min, max, inc, dec, int, from-int,
// compare, with saturation and divide-by-zero status.
//
//   port      dir  handshake             payload
//   i_word    in   start / busy          fpa_pkg::t_in
//   o_word    out  o_done (one cycle)    fpa_pkg::t_out
//
// One word accepted per cycle; busy is always low.
// Pipeline: input, operand, multiply, 10 divider stages (4 bits
// each), output. The divider pipeline sets the depth.
// Synchronous active-low reset clears all valid bits.
// ----------------------------------------------------------------------------
module fixed_point_alu (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  fpa_pkg::t_in  i_word,
    output logic          o_done,
    output fpa_pkg::t_out o_word
);

    localparam int W = fpa_pkg::WORD_BITS;
    localparam int F = fpa_pkg::FRAC_BITS;
    localparam int D = fpa_pkg::DVD_BITS;

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    assign busy = 1'b0;

    logic          r_v1;
    fpa_pkg::t_in  r_in1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
        r_in1 <= i_word;
    end

    // operand stage
    logic signed [W-1:0] a, b;
    logic [W-1:0]        n_ma, n_mb, n_simple;
    logic [1:0]          n_sst;
    logic signed [W:0]   sum, dif;

    assign a   = r_in1.operand_a;
    assign b   = r_in1.operand_b;
    assign sum = {a[W-1], a} + {b[W-1], b};
    assign dif = {a[W-1], a} - {b[W-1], b};

    always_comb begin
        n_ma     = a[W-1] ? (~a + 1'b1) : a;
        n_mb     = b[W-1] ? (~b + 1'b1) : b;
        n_simple = '0;
        n_sst    = fpa_pkg::ST_OK;
        unique case (r_in1.func)
            fpa_pkg::FN_ADD: begin
                if (sum[W] != sum[W-1]) begin
                    n_simple = sum[W] ? MINV : MAXV;
                    n_sst    = fpa_pkg::ST_OVF;
                end else begin
                    n_simple = sum[W-1:0];
                end
            end
            fpa_pkg::FN_SUB: begin
                if (dif[W] != dif[W-1]) begin
                    n_simple = dif[W] ? MINV : MAXV;
                    n_sst    = fpa_pkg::ST_OVF;
                end else begin
                    n_simple = dif[W-1:0];
                end
            end
            fpa_pkg::FN_MIN: n_simple = (a < b) ? a : b;
            fpa_pkg::FN_MAX: n_simple = (a > b) ? a : b;
            fpa_pkg::FN_INC: begin
                if (a == MAXV) begin
                    n_simple = MAXV;
                    n_sst    = fpa_pkg::ST_OVF;
                end else begin
                    n_simple = a + 1'b1;
                end
            end
            fpa_pkg::FN_DEC: begin
                if (a == MINV) begin
                    n_simple = MINV;
                    n_sst    = fpa_pkg::ST_OVF;
                end else begin
                    n_simple = a - 1'b1;
                end
            end
            fpa_pkg::FN_INT: n_simple = a >>> F;
            fpa_pkg::FN_FRM: begin
                if (a[W-1:W-1-F] != {(F+1){a[W-1]}}) begin
                    n_simple = a[W-1] ? MINV : MAXV;
                    n_sst    = fpa_pkg::ST_OVF;
                end else begin
                    n_simple = a <<< F;
                end
            end
            default: n_simple = '0;
        endcase
    end

    logic           r_v2;
    logic [W-1:0]   r_ma, r_mb;
    fpa_pkg::t_side r_side2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_side2 <= '{func:      r_in1.func,
                     neg:       a[W-1] ^ b[W-1],
                     simple:    n_simple,
                     simple_st: n_sst,
                     less:      a < b,
                     equal:     a == b,
                     greater:   a > b,
                     prod:      '0};
    end

    // multiply stage
    logic           r_v3;
    logic [D-1:0]   r_dvd;
    logic [W-1:0]   r_dvs;
    fpa_pkg::t_side r_side3;
    logic [2*W-1:0] n_prod;

    assign n_prod = r_ma * r_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_dvd   <= {r_ma, {F{1'b0}}};
        r_dvs   <= r_mb;
        r_side3 <= '{func:      r_side2.func,
                     neg:       r_side2.neg,
                     simple:    r_side2.simple,
                     simple_st: r_side2.simple_st,
                     less:      r_side2.less,
                     equal:     r_side2.equal,
                     greater:   r_side2.greater,
                     prod:      n_prod};
    end

    logic           d_vld;
    logic [D-1:0]   d_quo;
    logic [W-1:0]   d_rem, d_dvs;
    fpa_pkg::t_side d_side;

    fpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_dvd   (r_dvd),
        .i_dvs   (r_dvs),
        .i_side  (r_side3),
        .o_valid (d_vld),
        .o_quo   (d_quo),
        .o_rem   (d_rem),
        .o_dvs   (d_dvs),
        .o_side  (d_side)
    );

    // round, sign, saturate
    logic [2*W-1:0] prod_r, mag, lim;
    logic           rnd;
    fpa_pkg::t_out  n_out;

    always_comb begin
        prod_r = d_side.prod + (64'(1) << (F - 1));
        rnd    = {d_rem, 1'b0} >= {1'b0, d_dvs};
        mag    = '0;
        lim    = d_side.neg ? {{W{1'b0}}, MINV} : {{W{1'b0}}, MAXV};
        n_out.less    = d_side.less;
        n_out.equal   = d_side.equal;
        n_out.greater = d_side.greater;
        n_out.result  = d_side.simple;
        n_out.status  = d_side.simple_st;
        if (d_side.func == fpa_pkg::FN_MUL || d_side.func == fpa_pkg::FN_DIV) begin
            if (d_side.func == fpa_pkg::FN_MUL) begin
                mag = prod_r >> F;
            end else begin
                mag = (2*W)'(d_quo) + (2*W)'(rnd);
            end
            if (mag > lim) begin
                n_out.result = d_side.neg ? MINV : MAXV;
                n_out.status = fpa_pkg::ST_OVF;
            end else begin
                n_out.result = d_side.neg ? (~mag[W-1:0] + 1'b1) : mag[W-1:0];
                n_out.status = fpa_pkg::ST_OK;
            end
            if (d_side.func == fpa_pkg::FN_DIV && d_dvs == '0) begin
                n_out.result = '0;
                n_out.status = fpa_pkg::ST_DIV0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= d_vld;
        end
        o_word <= n_out;
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, fpa_pkg::LATENCY))
        else $error("result without matching accepted word");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $onehot({o_word.less, o_word.equal, o_word.greater}))
        else $error("compare flags not one-hot");

    a_div0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_word.status == fpa_pkg::ST_DIV0 |-> o_word.result == '0)
        else $error("divide by zero with nonzero result");

endmodule

/* bench/fixed_point_alu_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_tb
// Self-checking bench for the Q24.8 fixed-point ALU. Words are sent through
// the start/busy handshake; an internal integer model predicts each result
// (saturation, rounding half away from zero, divide-by-zero, flags) and a
// checker compares every strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module fixed_point_alu_tb;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    fpa_pkg::t_in   i_word;
    logic           o_done;
    fpa_pkg::t_out  o_word;

    fpa_pkg::t_out  alu_expected[$];
    int    mismatches;
    int    cycles;
    int    idle_pct;

    localparam int CYCLE_LIMIT = 400000;

    fixed_point_alu DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_word  (i_word),
        .o_done  (o_done),
        .o_word  (o_word)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint clamp_word(longint v, ref logic [1:0] st);
        longint hi;
        longint lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            st = fpa_pkg::ST_OVF;
            return hi;
        end
        if (v < lo) begin
            st = fpa_pkg::ST_OVF;
            return lo;
        end
        return v;
    endfunction

    function automatic fpa_pkg::t_out alu_predict(fpa_pkg::t_in w);
        fpa_pkg::t_out r;
        longint a;
        longint b;
        longint ma;
        longint mb;
        longint q;
        longint rem;
        longint v;
        bit     neg;
        logic [1:0] st;
        a   = longint'(w.operand_a);
        b   = longint'(w.operand_b);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        neg = (a < 0) != (b < 0);
        st  = fpa_pkg::ST_OK;
        v   = 0;
        unique case (w.func)
            fpa_pkg::FN_ADD: v = clamp_word(a + b, st);
            fpa_pkg::FN_SUB: v = clamp_word(a - b, st);
            fpa_pkg::FN_MUL: begin
                q = (ma * mb + (64'sd1 <<< (fpa_pkg::FRAC_BITS - 1))) >>> fpa_pkg::FRAC_BITS;
                v = clamp_word(neg ? -q : q, st);
            end
            fpa_pkg::FN_DIV: begin
                if (mb == 0) begin
                    st = fpa_pkg::ST_DIV0;
                end else begin
                    q   = (ma <<< fpa_pkg::FRAC_BITS) / mb;
                    rem = (ma <<< fpa_pkg::FRAC_BITS) % mb;
                    if (rem >= mb - rem) q++;
                    v = clamp_word(neg ? -q : q, st);
                end
            end
            fpa_pkg::FN_MIN: v = (a < b) ? a : b;
            fpa_pkg::FN_MAX: v = (a > b) ? a : b;
            fpa_pkg::FN_INC: v = clamp_word(a + 1, st);
            fpa_pkg::FN_DEC: v = clamp_word(a - 1, st);
            fpa_pkg::FN_INT: v = a >>> fpa_pkg::FRAC_BITS;
            fpa_pkg::FN_FRM: v = clamp_word(a * (64'sd1 <<< fpa_pkg::FRAC_BITS), st);
            default: v = 0;
        endcase
        r.result  = v[31:0];
        r.less    = a < b;
        r.equal   = a == b;
        r.greater = a > b;
        r.status  = st;
        return r;
    endfunction

    task automatic send_word(logic [3:0] fn, logic [31:0] opa, logic [31:0] opb);
        fpa_pkg::t_in w;
        w.func      = fn;
        w.operand_a = opa;
        w.operand_b = opb;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (busy);
        alu_expected.push_back(alu_predict(w));
    endtask

    function automatic logic [31:0] rand_operand();
        unique case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(2047) - 1024;
            2: return {$urandom_range(1) ? 8'hFF : 8'h00, 24'($urandom)};
            3: return 32'h8000_0000 + $urandom_range(3) - 1;
            4: return 32'h7FFF_FFFF - $urandom_range(3) + 1;
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] edges[6];
        edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h100, 32'h1};
        for (int f = 0; f < 16; f++) send_word(f[3:0], edges[f % 6], edges[(f + 2) % 6]);
        send_word(fpa_pkg::FN_DIV, 32'h100, 32'h0);
        send_word(fpa_pkg::FN_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_word(fpa_pkg::FN_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(fpa_pkg::FN_MUL, 32'hFFFF_FFFF, 32'h80);
        send_word(fpa_pkg::FN_MUL, 32'h1, 32'h7F);
        send_word(fpa_pkg::FN_DIV, 32'h1, 32'h200);
        send_word(fpa_pkg::FN_FRM, 32'hFF80_0000, 32'h0);
        send_word(fpa_pkg::FN_INT, 32'hFFFF_FF01, 32'h0);
        send_word(fpa_pkg::FN_DEC, 32'h8000_0000, 32'h0);
    endtask

    task automatic test_random(int n, int pct);
        logic [31:0] x;
        idle_pct = pct;
        for (int i = 0; i < n; i++) begin
            x = rand_operand();
            send_word(4'($urandom_range(15)), x,
                      ($urandom_range(9) == 0) ? x : rand_operand());
        end
    endtask

    always @(posedge i_clk) begin
        fpa_pkg::t_out e;
        if (i_rst_n && o_done) begin
            if (alu_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", o_word);
            end else begin
                e = alu_expected.pop_front();
                if (o_word !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word: exp %h l%b e%b g%b st%0d, got %h l%b e%b g%b st%0d",
                                 e.result, e.less, e.equal, e.greater, e.status,
                                 o_word.result, o_word.less, o_word.equal,
                                 o_word.greater, o_word.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("fixed_point_alu: mismatch");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        cycles     = 0;
        idle_pct   = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_word     = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(300, 0);
        test_random(280, 87);
        test_random(260, 13);
        test_random(260, 0);
        start <= 1'b0;
        while (alu_expected.size() != 0) @(posedge i_clk);
        repeat (fpa_pkg::LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("fixed_point_alu: match");
        end else begin
            $display("fixed_point_alu: mismatch");
        end
        $finish;
    end
endmodule

/* sim.f */
src/fpa_pkg.sv
src/fpa_div.sv
src/fixed_point_alu.sv
bench/fixed_point_alu_tb.sv
